FILE: design/het_pkg.sv
// Package for the hysteresis edge trigger: shared types and constants.
// Used by het_front, het_queue, het_back and hysteresis_edge_trigger.
`default_nettype none
package het_pkg;

  // Config register indexes
  localparam logic [1:0] CFG_LEVEL = 2'd0;
  localparam logic [1:0] CFG_HYST  = 2'd1;
  localparam logic [1:0] CFG_MODE  = 2'd2;
  localparam logic [1:0] CFG_PRE   = 2'd3;

  // Edge mode codes
  localparam logic [1:0] MODE_RISE = 2'd0;
  localparam logic [1:0] MODE_FALL = 2'd1;

  // Reset values of the config registers
  localparam logic signed [13:0] LEVEL_RST = 14'sd0;
  localparam logic [13:0]        HYST_RST  = 14'd200;
  localparam logic [1:0]         MODE_RST  = MODE_RISE;
  localparam logic [12:0]        PRE_RST   = 13'd2048;

  // Millivolt scaling: mv = raw * MV_SCALE / 256, truncated toward zero
  localparam logic signed [21:0] MV_SCALE = 22'sd10000;

  // Width of the band compare (level +/- half band)
  localparam int BW = 16;

  // Phase of the hysteresis machine
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_BELOW = 2'd1,
    PH_BAND  = 2'd2
  } phase_t;

  // Classified sample word passed from front to back
  typedef struct packed {
    logic frame_start;
    logic active;   // triggering enabled
    logic below;    // v < lower
    logic above;    // v > upper
    logic in_band;  // lower < v < upper
  } cls_t;

endpackage
`default_nettype wire

FILE: design/het_front.sv
// Front end: config registers, millivolt scaling and band classification.
// Depends on het_pkg.
`default_nettype none
module het_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic cfg_valid,
  input  wire                logic [1:0] cfg_index,
  input  wire                logic [13:0] cfg_data,
  input  wire                logic signed [7:0] raw_sample,
  input  wire                logic frame_start,
  output het_pkg::cls_t      cls,
  output logic [12:0]        pretrigger
);
  import het_pkg::*;

  logic signed [13:0] level_r;
  logic [13:0]        hyst_r;
  logic [1:0]         mode_r;
  logic [12:0]        pre_r;

  logic signed [21:0]   prod;
  logic signed [21:0]   prod_adj;
  logic signed [13:0]   mv;
  logic signed [BW-1:0] v;
  logic signed [BW-1:0] upper;
  logic signed [BW-1:0] lower;
  logic signed [BW-1:0] half;

  // Config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_RST;
      hyst_r  <= HYST_RST;
      mode_r  <= MODE_RST;
      pre_r   <= PRE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL: level_r <= cfg_data;
        CFG_HYST:  hyst_r  <= cfg_data;
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_PRE:   pre_r   <= cfg_data[12:0];
        default:   ;
      endcase
    end
  end

  assign pretrigger = pre_r;

  // Scale to mV, round toward zero, invert for falling edge
  always_comb begin
    prod     = 22'(raw_sample) * MV_SCALE;
    prod_adj = prod + ((prod < 0) ? 22'sd255 : 22'sd0);
    mv       = 14'(prod_adj >>> 8);
    v        = (mode_r == MODE_FALL) ? -BW'(mv) : BW'(mv);
  end

  // Band edges and classification
  always_comb begin
    half  = $signed({{(BW-13){1'b0}}, hyst_r[13:1]});
    upper = BW'(level_r) + half;
    lower = BW'(level_r) - half;
    cls.frame_start = frame_start;
    cls.active      = (mode_r == MODE_RISE) || (mode_r == MODE_FALL);
    cls.below       = v < lower;
    cls.above       = v > upper;
    cls.in_band     = (v > lower) && (v < upper);
  end

endmodule
`default_nettype wire

FILE: design/het_queue.sv
// Two-entry queue that decouples the front end from the trigger back end.
// Depends on het_pkg.
`default_nettype none
module het_queue (
  input  wire           logic clk,
  input  wire           logic rst_n,
  input  wire           logic push,
  input  het_pkg::cls_t push_word,
  input  wire           logic pop,
  output het_pkg::cls_t pop_word,
  output logic          full,
  output logic          empty
);
  import het_pkg::*;

  cls_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  assign pop_word = mem[rd_ptr_r];
  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);

  // Pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/het_back.sv
// Back end: hysteresis phase machine, trigger position, window check,
// trigger count and the output register. Depends on het_pkg.
`default_nettype none
module het_back #(
  parameter int FRAME_LENGTH  = 8192,
  parameter int WINDOW_LENGTH = 4096,
  parameter int MAX_TRIGGERS  = 128
) (
  input  wire           logic clk,
  input  wire           logic rst_n,
  input  het_pkg::cls_t cls,
  input  wire           logic cls_avail,
  output logic          cls_take,
  input  wire           logic [12:0] pretrigger,
  output logic          out_valid,
  input  wire           logic out_stall,
  output logic          out_trigger_hit,
  output logic [12:0]   out_trigger_index,
  output logic          out_window_accept,
  output logic          out_captured,
  output logic [7:0]    out_trigger_total
);
  import het_pkg::*;

  localparam int IW   = $clog2(FRAME_LENGTH + 1);
  localparam int WW   = $clog2(WINDOW_LENGTH + 1);
  localparam int CNTW = $clog2(MAX_TRIGGERS + 1);
  localparam int PW   = (IW > 13) ? IW : 13;
  localparam int TW   = (CNTW > 8) ? CNTW : 8;
  localparam int CW0  = (IW > WW) ? IW : WW;
  localparam int CW   = ((CW0 > 13) ? CW0 : 13) + 1;

  phase_t          phase_r, phase_nxt, ph;
  logic [IW-1:0]   entry_r, entry_nxt, entry;
  logic [IW-1:0]   idx_r, idx_nxt, idx;
  logic [CNTW-1:0] cnt_r, cnt_nxt, cnt;
  logic            lock_r, lock_nxt, lock;

  logic          hit, acc;
  logic [IW-1:0] pos;
  logic [IW:0]   mid_sum;
  logic [CW-1:0] pos_w, pre_w, lim_w;
  logic [PW-1:0] pos_ext;
  logic [TW-1:0] cnt_ext;

  logic        out_valid_r;
  logic        hit_r, acc_r, lock_out_r;
  logic [12:0] index_r;
  logic [7:0]  total_r;

  // Take a word whenever the output register is free or being drained
  assign cls_take = cls_avail && (!out_valid_r || !out_stall);

  // Phase machine and trigger bookkeeping
  always_comb begin
    ph    = phase_r;
    entry = entry_r;
    idx   = idx_r;
    cnt   = cnt_r;
    lock  = lock_r;
    if (cls.frame_start) begin
      ph    = PH_WAIT;
      entry = '0;
      idx   = '0;
      cnt   = '0;
      lock  = 1'b0;
    end
    phase_nxt = ph;
    entry_nxt = entry;
    idx_nxt   = idx;
    cnt_nxt   = cnt;
    lock_nxt  = lock;
    hit       = 1'b0;
    acc       = 1'b0;
    pos       = '0;
    mid_sum   = {1'b0, entry} + {1'b0, idx};
    pos_w     = '0;
    pre_w     = CW'(pretrigger);
    lim_w     = CW'(pretrigger) + CW'(WINDOW_LENGTH);
    if (idx < IW'(FRAME_LENGTH)) begin
      if (cls.active) begin
        case (ph)
          PH_WAIT: begin
            if (cls.below) phase_nxt = PH_BELOW;
          end
          PH_BELOW: begin
            if (cls.above) begin
              hit       = 1'b1;
              pos       = idx;
              phase_nxt = PH_WAIT;
            end else if (cls.in_band) begin
              phase_nxt = PH_BAND;
              entry_nxt = idx;
            end
          end
          PH_BAND: begin
            if (cls.below) begin
              phase_nxt = PH_BELOW;
            end else if (cls.above) begin
              hit       = 1'b1;
              pos       = mid_sum[IW:1];
              phase_nxt = PH_WAIT;
            end
          end
          default: ;
        endcase
      end
      // Window fit and saturating count
      pos_w = CW'(pos);
      if (hit) begin
        if (!lock && pos_w >= pre_w && pos_w < lim_w) begin
          acc      = 1'b1;
          lock_nxt = 1'b1;
        end
        if (cnt < CNTW'(MAX_TRIGGERS)) cnt_nxt = cnt + 1'b1;
      end
      idx_nxt = idx + 1'b1;
    end
    pos_ext = PW'(pos);
    cnt_ext = TW'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      entry_r <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      lock_r  <= 1'b0;
    end else if (cls_take) begin
      phase_r <= phase_nxt;
      entry_r <= entry_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      lock_r  <= lock_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cls_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_take) begin
      hit_r      <= hit;
      index_r    <= pos_ext[12:0];
      acc_r      <= acc;
      lock_out_r <= lock_nxt;
      total_r    <= (cnt_ext > TW'(255)) ? 8'hFF : cnt_ext[7:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_hit   = hit_r;
  assign out_trigger_index = index_r;
  assign out_window_accept = acc_r;
  assign out_captured      = lock_out_r;
  assign out_trigger_total = total_r;

endmodule
`default_nettype wire

FILE: design/hysteresis_edge_trigger.sv
// Hysteresis edge trigger, top level. An accepted input word enters the queue at the
// accept edge and the output register at a later edge, when the back end pops it.
// Throughput: one word per cycle unless stalled; the back end pops the queue every cycle the
// output register is free or draining. Synchronous active-low reset clears the
// phase machine, frame counters, queue and output valid, and loads the config
// defaults (level 0 mV, band 200 mV, rising edge, pretrigger 2048).
`default_nettype none
module hysteresis_edge_trigger #(
  parameter int FRAME_LENGTH  = 8192,
  parameter int WINDOW_LENGTH = 4096,
  parameter int MAX_TRIGGERS  = 128
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic cfg_valid,
  output logic       cfg_ready,
  input  wire  logic [1:0] cfg_index,
  input  wire  logic [13:0] cfg_data,
  input  wire  logic in_valid,
  output logic       in_stall,
  input  wire  logic signed [7:0] in_raw_sample,
  input  wire  logic in_frame_start,
  output logic       out_valid,
  input  wire  logic out_stall,
  output logic       out_trigger_hit,
  output logic [12:0] out_trigger_index,
  output logic       out_window_accept,
  output logic       out_captured,
  output logic [7:0] out_trigger_total
);
  import het_pkg::*;

  cls_t        front_cls;
  cls_t        back_cls;
  logic [12:0] pretrigger;
  logic        q_full, q_empty, q_pop, q_push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  het_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raw_sample  (in_raw_sample),
    .frame_start (in_frame_start),
    .cls         (front_cls),
    .pretrigger  (pretrigger)
  );

  het_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (front_cls),
    .pop       (q_pop),
    .pop_word  (back_cls),
    .full      (q_full),
    .empty     (q_empty)
  );

  het_back #(
    .FRAME_LENGTH  (FRAME_LENGTH),
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .MAX_TRIGGERS  (MAX_TRIGGERS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cls               (back_cls),
    .cls_avail         (!q_empty),
    .cls_take          (q_pop),
    .pretrigger        (pretrigger),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_hit   (out_trigger_hit),
    .out_trigger_index (out_trigger_index),
    .out_window_accept (out_window_accept),
    .out_captured      (out_captured),
    .out_trigger_total (out_trigger_total)
  );

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for hysteresis_edge_trigger: directed and random ADC frames with
// a scoreboard that predicts every result word. Needs het_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import het_pkg::*;

  localparam int FRAME_LEN   = 8192;
  localparam int WINDOW_LEN  = 4096;
  localparam int MAX_TRIG    = 128;
  localparam int CYCLE_LIMIT = 400000;

  // Disabled edge modes (both codes disable triggering)
  localparam logic [1:0] MODE_OFF     = 2'd2;
  localparam logic [1:0] MODE_OFF_ALT = 2'd3;

  // Expected result word, one per accepted sample
  typedef struct packed {
    logic        hit;
    logic [12:0] index;
    logic        accept;
    logic        captured;
    logic [7:0]  total;
  } trig_result_t;

  // Where a generated sample lands relative to the band
  typedef enum {RG_BELOW, RG_INSIDE, RG_ABOVE, RG_ON_LOWER, RG_ON_UPPER, RG_ANY} region_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index      = '0;
  logic [13:0]       cfg_data       = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic signed [7:0] in_raw_sample  = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_trigger_hit;
  logic [12:0]       out_trigger_index;
  logic              out_window_accept;
  logic              out_captured;
  logic [7:0]        out_trigger_total;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  // Trigger scoreboard: tracks config and frame state, queues the due words
  class trigger_tracker;
    int           level, hyst, pre;
    logic [1:0]   mode;
    phase_t       ph;
    int           entry_idx, smp_idx, trig_cnt;
    bit           locked;
    trig_result_t due_results[$];
    int           errors;

    function new();
      level  = LEVEL_RST;
      hyst   = HYST_RST;
      mode   = MODE_RST;
      pre    = PRE_RST;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph        = PH_WAIT;
      entry_idx = 0;
      smp_idx   = 0;
      trig_cnt  = 0;
      locked    = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [13:0] data);
      case (idx)
        CFG_LEVEL: level = $signed(data);
        CFG_HYST:  hyst  = data;
        CFG_MODE:  mode  = data[1:0];
        CFG_PRE:   pre   = data[12:0];
        default: ;
      endcase
    endfunction

    // Advance the phase machine by one sample and queue the word it yields
    function void take_sample(logic signed [7:0] raw, logic fs);
      int           v, half, upper, lower, pos;
      bit           hit;
      trig_result_t r;
      r   = '0;
      hit = 1'b0;
      pos = 0;
      if (fs) clear_frame();
      if (smp_idx < FRAME_LEN) begin
        v     = (int'(raw) * 10000) / 256;
        half  = hyst / 2;
        upper = level + half;
        lower = level - half;
        if (mode == MODE_RISE || mode == MODE_FALL) begin
          if (mode == MODE_FALL) v = -v;
          case (ph)
            PH_WAIT: if (v < lower) ph = PH_BELOW;
            PH_BELOW: begin
              if (v > upper) begin
                hit = 1'b1;
                pos = smp_idx;
                ph  = PH_WAIT;
              end else if (v > lower && v < upper) begin
                ph        = PH_BAND;
                entry_idx = smp_idx;
              end
            end
            default: begin
              if (v < lower) begin
                ph = PH_BELOW;
              end else if (v > upper) begin
                hit = 1'b1;
                pos = (entry_idx + smp_idx) / 2;
                ph  = PH_WAIT;
              end
            end
          endcase
        end
        if (hit) begin
          // first trigger whose display window fits locks the capture
          if (!locked && pos >= pre && pos < WINDOW_LEN + pre) begin
            r.accept = 1'b1;
            locked   = 1'b1;
          end
          if (trig_cnt < MAX_TRIG) trig_cnt++;
        end
        smp_idx++;
      end
      r.hit      = hit;
      r.index    = hit ? pos[12:0] : 13'd0;
      r.captured = locked;
      r.total    = (trig_cnt > 255) ? 8'd255 : trig_cnt[7:0];
      due_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task match_result(trig_result_t got);
      trig_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word with no sample pending (hit %0b index %0d)",
                         got.hit, got.index));
        return;
      end
      want = due_results.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("trigger_hit %b, want %b", got.hit, want.hit));
      if (got.index !== want.index)
        report($sformatf("trigger_index %0d, want %0d", got.index, want.index));
      if (got.accept !== want.accept)
        report($sformatf("window_accept %b, want %b", got.accept, want.accept));
      if (got.captured !== want.captured)
        report($sformatf("captured %b, want %b", got.captured, want.captured));
      if (got.total !== want.total)
        report($sformatf("trigger_total %0d, want %0d", got.total, want.total));
    endtask
  endclass

  trigger_tracker tracker;
  trig_result_t   seen;

  hysteresis_edge_trigger #(
    .FRAME_LENGTH (FRAME_LEN),
    .WINDOW_LENGTH(WINDOW_LEN),
    .MAX_TRIGGERS (MAX_TRIG)
  ) uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_trigger_hit, out_trigger_index, out_window_accept, out_captured,
              out_trigger_total};
      tracker.match_result(seen);
    end
  end

  // Random sample whose band position matches the requested region
  function automatic logic signed [7:0] pick_sample(region_t rg);
    int                half, upper, lower, v;
    bit                ok;
    logic signed [7:0] pool[$];
    half  = tracker.hyst / 2;
    upper = tracker.level + half;
    lower = tracker.level - half;
    for (int r = -128; r <= 127; r++) begin
      v = (r * 10000) / 256;
      if (tracker.mode == MODE_FALL) v = -v;
      case (rg)
        RG_BELOW:    ok = v < lower;
        RG_INSIDE:   ok = v > lower && v < upper;
        RG_ABOVE:    ok = v > upper;
        RG_ON_LOWER: ok = v == lower;
        RG_ON_UPPER: ok = v == upper;
        default:     ok = 1'b1;
      endcase
      if (ok) pool.push_back(8'(r));
    end
    if (pool.size() == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  task automatic send_sample(input logic signed [7:0] raw, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_raw_sample  <= raw;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_sample(raw, fs);
  endtask

  // Hold the sender until every due word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int level, input int hyst, input logic [1:0] mode,
                            input int pre);
    drain();
    write_reg(CFG_LEVEL, 14'(level));
    write_reg(CFG_HYST, 14'(hyst));
    write_reg(CFG_MODE, 14'(mode));
    write_reg(CFG_PRE, 14'(pre));
  endtask

  // One frame: mostly below/inside/above passes, some noise and bound hits
  task automatic play_frame(input int len, input bit restart);
    region_t plan[$];
    int      seg;
    while (plan.size() < len) begin
      seg = $urandom_range(99);
      if (seg < 10) begin
        repeat ($urandom_range(1, 4)) plan.push_back(RG_ANY);
      end else if (seg < 16) begin
        plan.push_back($urandom_range(1) ? RG_ON_LOWER : RG_ON_UPPER);
      end else begin
        repeat ($urandom_range(1, 3)) plan.push_back(RG_BELOW);
        if ($urandom_range(1)) repeat ($urandom_range(1, 5)) plan.push_back(RG_INSIDE);
        // broken pass: drop back below before crossing
        if ($urandom_range(4) == 0) plan.push_back(RG_BELOW);
        repeat ($urandom_range(1, 2)) plan.push_back(RG_ABOVE);
      end
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(149) == 0) drain();
      send_sample(pick_sample(plan[k]), restart && k == 0);
    end
  endtask

  initial begin
    int budget, len, lv, hy, pr;
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: band edges at +/-78 mV so raw +/-2 sits exactly on them
    set_config(0, 156, MODE_RISE, 0);
    send_sample(8'sd0, 1'b1);
    send_sample(-8'sd3, 1'b0);    // below band
    send_sample(8'sd2, 1'b0);     // on upper bound: stays below
    send_sample(-8'sd2, 1'b0);    // on lower bound: stays below
    send_sample(8'sd127, 1'b0);   // direct crossing, first fitting window
    send_sample(-8'sd128, 1'b0);
    send_sample(8'sd0, 1'b0);     // band entry
    send_sample(8'sd1, 1'b0);
    send_sample(8'sd0, 1'b0);
    send_sample(8'sd127, 1'b0);   // lingering pass, midpoint trigger
    send_sample(-8'sd128, 1'b0);
    send_sample(8'sd0, 1'b0);
    send_sample(-8'sd128, 1'b0);  // back below from inside the band
    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd128, 1'b1);  // restart mid-stream
    send_sample(8'sd127, 1'b0);
    set_config(0, 156, MODE_FALL, 0);
    send_sample(8'sd127, 1'b1);
    send_sample(-8'sd128, 1'b0);
    set_config(0, 156, MODE_OFF, 0);
    send_sample(-8'sd128, 1'b1);
    send_sample(8'sd127, 1'b0);

    // Random frames over several settings and idle patterns
    for (int k = 0; k < 12; k++) begin
      lv = int'($urandom_range(6000)) - 3000;
      hy = $urandom_range(3) == 0 ? 0 : $urandom_range(3000);
      pr = $urandom_range(150);
      case (k)
        0: set_config(-5000, 10000, MODE_RISE, 0);
        1: set_config(5000, 0, MODE_FALL, 8191);
        2: set_config(lv, hy, MODE_OFF, pr);
        3: set_config(lv, hy, MODE_OFF_ALT, pr);
        default: set_config(lv, hy, $urandom_range(1) ? MODE_FALL : MODE_RISE, pr);
      endcase
      case (k % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      budget = 60;
      while (budget > 0) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 160) : $urandom_range(8, 60);
        play_frame(len, $urandom_range(9) != 0);
        budget -= len;
      end
    end

    // Dense frame: a trigger every other sample, count saturation, late window
    set_config(0, 156, MODE_RISE, $urandom_range(40, 250));
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int k = 0; k < 300; k++)
      send_sample((k % 2 == 0) ? -8'sd128 : 8'sd127, k == 0);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/het_pkg.sv
design/het_front.sv
design/het_queue.sv
design/het_back.sv
design/hysteresis_edge_trigger.sv
sim/tb.sv
